[rtl/core/ring_cylinder_segment_tessellator_assert.svh]
// Assertion macros shared by the tessellator RTL
`ifndef RING_CYLINDER_SEGMENT_TESSELLATOR_ASSERT_SVH
`define RING_CYLINDER_SEGMENT_TESSELLATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset
`define RCST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define RCST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rcst_pkg.sv]
// Types and constant tables for the ring/cylinder segment tessellator
package rcst_pkg;

  typedef enum logic [2:0] {
    CFG_SHAPE_MODE    = 3'd0,
    CFG_SEGMENT_COUNT = 3'd1,
    CFG_OUTER_RADIUS  = 3'd2,
    CFG_INNER_RADIUS  = 3'd3,
    CFG_WALL_HEIGHT   = 3'd4
  } cfg_reg_t;

  // pi/2 in Q1.32
  localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;
  localparam logic [34:0] ONE_Q32     = 35'd4294967296;

  localparam int PH_BITS       = 17;  // quotient bits of the phase divide
  localparam int DIV_STEPS_PER = 4;   // restoring steps per divider stage
  localparam int NTERMS        = 6;   // series terms after the first
  localparam int VERTS         = 6;

  // Series divisors and their reciprocals: q ~= (p * RECIP) >> SHIFT
  localparam logic [7:0]  SIN_DIV   [NTERMS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
  localparam logic [31:0] SIN_RECIP [NTERMS] = '{32'd2863311530, 32'd3435973836,
                                                 32'd3272356035, 32'd3817748707,
                                                 32'd2498890063, 32'd3524075730};
  localparam int          SIN_SHIFT [NTERMS] = '{34, 36, 37, 38, 38, 39};

  localparam logic [7:0]  COS_DIV   [NTERMS] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
  localparam logic [31:0] COS_RECIP [NTERMS] = '{32'd2147483648, 32'd2863311530,
                                                 32'd2290649224, 32'd2454267026,
                                                 32'd3054198966, 32'd4164816771};
  localparam int          COS_SHIFT [NTERMS] = '{32, 35, 36, 37, 38, 39};

  // Per vertex: take the slice end phase, take the inner/bottom radius
  localparam logic [VERTS-1:0] USE_NEXT  = 6'b110010;
  localparam logic [VERTS-1:0] USE_INNER = 6'b101100;

endpackage

[rtl/core/ring_cylinder_segment_tessellator.sv]
// Top level: segment index in, six slice vertices out, fully pipelined trig
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_stall  | segment_index
//   out     | out_valid/ out_stall | pos_x/y/z, tex_u/v, norm_x/y/z, flags
//   cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// A slice passes 28 register stages: capture, a 5-stage restoring divider
// for both phases, angle and square stages, 18 stages of Taylor terms (product,
// reciprocal multiply, correction per term), rounding and radius scaling.
// The first vertex comes from an output buffer registered after the last stage;
// a slice then takes 6 output transfers (1 for an index error), and the single
// vertex port takes a new slice only as the previous one's last vertex is sent.
// Reset clears the stage valid bits and the output buffer's valid bit and vertex counter; config goes to defaults.
// A stalled output freezes every stage together; nothing is dropped or repeated.
module ring_cylinder_segment_tessellator #(
  parameter int MAX_SEGMENTS   = 1024,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [9:0]          segment_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [16:0]  pos_x,
  output logic signed [16:0]  pos_y,
  output logic signed [16:0]  pos_z,
  output logic [16:0]         tex_u,
  output logic                tex_v,
  output logic signed [15:0]  norm_x,
  output logic signed [15:0]  norm_y,
  output logic signed [15:0]  norm_z,
  output logic                index_error,
  output logic                last_vertex,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import rcst_pkg::*;

  localparam int TW         = TRIG_FRAC_BITS + 2;          // signed trig width
  localparam int MW         = TW + 16;                     // trig * radius
  localparam int RS         = 32 - TRIG_FRAC_BITS;         // Q0.32 -> Q1.F shift
  localparam logic [34:0] TRIG_HALF = 35'd1 << (RS - 1);
  localparam logic [34:0] TRIG_ONE  = 35'd1 << TRIG_FRAC_BITS;
  localparam logic [MW-1:0] SCL_HALF = MW'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic [63:0] ONE_T     = 64'd1 << TRIG_FRAC_BITS;
  localparam logic [15:0] RING_NZ   = ONE_T[15:0];

  localparam int DIV_STAGES = (PH_BITS + DIV_STEPS_PER - 1) / DIV_STEPS_PER;
  localparam int X_STG      = DIV_STAGES + 1;
  localparam int X2_STG     = X_STG + 1;
  localparam int TERM0      = X2_STG + 1;
  localparam int RND_STG    = TERM0 + 3 * NTERMS;
  localparam int SCL_STG    = RND_STG + 1;
  localparam int NST        = SCL_STG + 1;

  typedef struct packed {
    logic                 vld;
    logic                 err;
    logic [1:0][16:0]     ph;
    logic [1:0][11:0]     rem;
    logic [1:0][31:0]     x;
    logic [1:0][31:0]     x2;
    logic [1:0][31:0]     t;
    logic [1:0][31:0]     tc;
    logic [1:0][31:0]     p;
    logic [1:0][31:0]     pc;
    logic [1:0][31:0]     e;
    logic [1:0][31:0]     ec;
    logic [1:0][34:0]     ss;
    logic [1:0][34:0]     sc;
    logic [1:0][TW-1:0]   sn;
    logic [1:0][TW-1:0]   cs;
    logic [1:0][1:0][16:0] px;
    logic [1:0][1:0][16:0] pz;
  } slice_t;

  // Configuration registers
  logic               shape_mode;
  logic [10:0]        segment_count;
  logic [15:0]        outer_radius;
  logic [15:0]        inner_radius;
  logic signed [15:0] wall_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode    <= 1'b0;
      segment_count <= 11'd32;
      outer_radius  <= 16'd256;
      inner_radius  <= 16'd128;
      wall_height   <= 16'sd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SHAPE_MODE:    shape_mode    <= cfg_data[0];
        CFG_SEGMENT_COUNT: segment_count <= cfg_data[10:0];
        CFG_OUTER_RADIUS:  outer_radius  <= cfg_data;
        CFG_INNER_RADIUS:  inner_radius  <= cfg_data;
        CFG_WALL_HEIGHT:   wall_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  // One pipeline stage's work; k and j pick the series term and its sub-step
  function automatic slice_t stage_fn(input int s, input int k, input int j,
                                      input slice_t d);
    slice_t       o;
    int           st;
    logic [11:0]  r2;
    logic         qb;
    logic [13:0]  rr;
    logic [13:0]  a;
    logic [47:0]  xm;
    logic [63:0]  pr;
    logic [63:0]  prc;
    logic [39:0]  ed;
    logic [31:0]  rm;
    logic [31:0]  q;
    logic [34:0]  vs;
    logic [34:0]  vc;
    logic [34:0]  rs_v;
    logic [34:0]  rc_v;
    logic [TW-1:0] fs;
    logic [TW-1:0] fc;
    logic [TW-1:0] mag;
    logic [MW-1:0] m;
    logic [15:0]  rad;
    o = d;
    priority if (s >= 1 && s <= DIV_STAGES) begin
      // Restoring divide: phase = floor(N * 65536 / segment_count)
      for (int l = 0; l < 2; l++) begin
        for (int jj = 0; jj < DIV_STEPS_PER; jj++) begin
          st = (s - 1) * DIV_STEPS_PER + jj;
          if (st < PH_BITS) begin
            r2 = (st == 0) ? o.rem[l] : {o.rem[l][10:0], 1'b0};
            qb = (r2 >= {1'b0, segment_count});
            if (qb) r2 = r2 - {1'b0, segment_count};
            o.rem[l] = r2;
            o.ph[l]  = {o.ph[l][15:0], qb};
          end
        end
      end
    end else if (s == X_STG) begin
      // Fold to the first octant, scale to radians in Q0.32
      for (int l = 0; l < 2; l++) begin
        rr = d.ph[l][13:0];
        a  = (rr > 14'd8192) ? 14'(15'd16384 - {1'b0, rr}) : rr;
        xm = 48'(a) * 48'(HALF_PI_Q32) + 48'd8192;
        o.x[l] = xm[45:14];
      end
    end else if (s == X2_STG) begin
      for (int l = 0; l < 2; l++) begin
        pr = 64'(d.x[l]) * 64'(d.x[l]);
        o.x2[l] = pr[63:32];
        o.t[l]  = d.x[l];
        o.tc[l] = '0;
        o.ss[l] = 35'(d.x[l]);
        o.sc[l] = ONE_Q32;
      end
    end else if (s >= TERM0 && s < RND_STG) begin
      for (int l = 0; l < 2; l++) begin
        unique case (j)
          0: begin
            pr  = 64'(d.t[l]) * 64'(d.x2[l]);
            prc = 64'(d.tc[l]) * 64'(d.x2[l]);
            o.p[l]  = pr[63:32];
            // first cosine term starts from 1.0, so its product is x^2 itself
            o.pc[l] = (k == 0) ? d.x2[l] : prc[63:32];
          end
          1: begin
            pr  = 64'(d.p[l]) * 64'(SIN_RECIP[k]);
            prc = 64'(d.pc[l]) * 64'(COS_RECIP[k]);
            o.e[l]  = 32'(pr >> SIN_SHIFT[k]);
            o.ec[l] = 32'(prc >> COS_SHIFT[k]);
          end
          default: begin
            // estimate is low by at most one; fix with one compare
            ed = 40'(d.e[l]) * 40'(SIN_DIV[k]);
            rm = d.p[l] - ed[31:0];
            q  = d.e[l] + 32'(rm >= 32'(SIN_DIV[k]));
            o.t[l]  = q;
            o.ss[l] = (k % 2 == 0) ? d.ss[l] - 35'(q) : d.ss[l] + 35'(q);
            ed = 40'(d.ec[l]) * 40'(COS_DIV[k]);
            rm = d.pc[l] - ed[31:0];
            q  = d.ec[l] + 32'(rm >= 32'(COS_DIV[k]));
            o.tc[l] = q;
            o.sc[l] = (k % 2 == 0) ? d.sc[l] - 35'(q) : d.sc[l] + 35'(q);
          end
        endcase
      end
    end else if (s == RND_STG) begin
      // Round to Q1.F, unfold the octant, apply quadrant signs
      for (int l = 0; l < 2; l++) begin
        vs   = d.ss[l][34] ? 35'd0 : d.ss[l];
        vc   = d.sc[l][34] ? 35'd0 : d.sc[l];
        rs_v = (vs + TRIG_HALF) >> RS;
        rc_v = (vc + TRIG_HALF) >> RS;
        if (rs_v > TRIG_ONE) rs_v = TRIG_ONE;
        if (rc_v > TRIG_ONE) rc_v = TRIG_ONE;
        if (d.ph[l][13:0] > 14'd8192) begin
          fs = TW'(rc_v);
          fc = TW'(rs_v);
        end else begin
          fs = TW'(rs_v);
          fc = TW'(rc_v);
        end
        unique case (d.ph[l][15:14])
          2'd0: begin o.sn[l] = fs;  o.cs[l] = fc;  end
          2'd1: begin o.sn[l] = fc;  o.cs[l] = -fs; end
          2'd2: begin o.sn[l] = -fs; o.cs[l] = -fc; end
          default: begin o.sn[l] = -fc; o.cs[l] = fs; end
        endcase
      end
    end else if (s == SCL_STG) begin
      // Scale by both radii, rounding symmetric about zero
      for (int l = 0; l < 2; l++) begin
        for (int i = 0; i < 2; i++) begin
          rad = (i == 1) ? inner_radius : outer_radius;
          mag = d.sn[l][TW-1] ? -d.sn[l] : d.sn[l];
          m   = (MW'(mag) * MW'(rad) + SCL_HALF) >> TRIG_FRAC_BITS;
          o.px[l][i] = d.sn[l][TW-1] ? m[16:0] : -m[16:0];
          mag = d.cs[l][TW-1] ? -d.cs[l] : d.cs[l];
          m   = (MW'(mag) * MW'(rad) + SCL_HALF) >> TRIG_FRAC_BITS;
          o.pz[l][i] = d.cs[l][TW-1] ? -m[16:0] : m[16:0];
        end
      end
    end else begin
      o = d;
    end
    return o;
  endfunction

  // Handshake and stage advance
  slice_t     pipe [NST];
  slice_t     cap;
  slice_t     obuf;
  logic [2:0] beat;
  logic       en;
  logic       out_xfer;
  logic       out_last;

  assign out_valid = obuf.vld;
  assign out_xfer  = out_valid && !out_stall;
  assign out_last  = obuf.err || (beat == 3'(VERTS - 1));
  // advance when the output buffer is empty or hands over its final vertex
  assign en        = !obuf.vld || (out_xfer && out_last);
  assign in_stall  = !en;

  always_comb begin
    cap        = '0;
    cap.vld    = in_valid;
    cap.err    = (segment_count == 11'd0) || (32'(segment_count) > MAX_SEGMENTS) ||
                 ({1'b0, segment_index} >= segment_count);
    cap.rem[0] = 12'(segment_index);
    cap.rem[1] = 12'(segment_index) + 12'd1;
  end

  for (genvar s = 0; s < NST; s++) begin : g_pipe
    localparam int K = (s >= TERM0 && s < RND_STG) ? (s - TERM0) / 3 : 0;
    localparam int J = (s >= TERM0 && s < RND_STG) ? (s - TERM0) % 3 : 0;
    slice_t din;
    if (s == 0) begin : g_head
      assign din = cap;
    end else begin : g_body
      assign din = pipe[s-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[s].vld <= 1'b0;
      end else if (en) begin
        pipe[s] <= stage_fn(s, K, J, din);
      end
    end
  end

  // Output buffer: hold the finished slice, step through its vertices
  always_ff @(posedge clk) begin
    if (rst) begin
      obuf.vld <= 1'b0;
      beat     <= '0;
    end else if (en) begin
      obuf <= pipe[NST-1];
      beat <= '0;
    end else if (out_xfer) begin
      beat <= beat + 3'd1;
    end
  end

  logic sel_e;
  logic sel_i;
  logic signed [63:0] nsx;
  logic signed [63:0] csx;

  always_comb begin
    sel_e = USE_NEXT[beat];
    sel_i = USE_INNER[beat];
    nsx   = -64'($signed(obuf.sn[sel_e]));
    csx   = 64'($signed(obuf.cs[sel_e]));
    pos_x       = '0;
    pos_y       = '0;
    pos_z       = '0;
    tex_u       = '0;
    tex_v       = 1'b0;
    norm_x      = '0;
    norm_y      = '0;
    norm_z      = '0;
    index_error = 1'b1;
    last_vertex = 1'b1;
    if (!obuf.err) begin
      index_error = 1'b0;
      last_vertex = (beat == 3'(VERTS - 1));
      tex_u       = obuf.ph[sel_e];
      tex_v       = sel_i;
      pos_x       = obuf.px[sel_e][sel_i];
      if (shape_mode) begin
        pos_y  = sel_i ? 17'sd0 : 17'(wall_height);
        pos_z  = obuf.pz[sel_e][sel_i];
        norm_x = nsx[15:0];
        norm_z = csx[15:0];
      end else begin
        pos_y  = obuf.pz[sel_e][sel_i];
        norm_z = RING_NZ;
      end
    end
  end

`include "ring_cylinder_segment_tessellator_assert.svh"

  `RCST_ASSERT_IMP(a_err_single, out_valid && index_error, last_vertex && tex_u == 17'd0, "error result must be a lone final vertex")
  `RCST_ASSERT_NXT(a_slice_runs_on, out_valid && !out_stall && !last_vertex, out_valid && !index_error, "slice ended before its sixth vertex")
  `RCST_ASSERT_IMP(a_no_take_while_busy, out_valid && !in_stall, !out_stall && last_vertex, "input taken while a slice is still being sent")

endmodule

[sim/rcst_checker.sv]
// Checker for the ring/cylinder tessellator: tracks config, predicts vertices, compares transfers
module rcst_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [9:0]         segment_index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [16:0] pos_x,
  input  logic signed [16:0] pos_y,
  input  logic signed [16:0] pos_z,
  input  logic [16:0]        tex_u,
  input  logic               tex_v,
  input  logic signed [15:0] norm_x,
  input  logic signed [15:0] norm_y,
  input  logic signed [15:0] norm_z,
  input  logic               index_error,
  input  logic               last_vertex,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 pending,
  output int                 fails
);
  timeunit 1ns;
  timeprecision 1ps;
  import rcst_pkg::*;

  typedef struct packed {
    logic signed [16:0] px, py, pz;
    logic [16:0]        u;
    logic               v;
    logic signed [15:0] nx, ny, nz;
    logic               err, last;
  } vertex_t;

  vertex_t     vertex_q[$];
  logic        shape_cyl;
  logic [10:0] seg_count;
  logic [15:0] rad_outer, rad_inner;
  logic signed [15:0] height;

  assign pending = vertex_q.size();

  // Sine and cosine of x in Q0.32 (0..pi/4) by truncated Taylor series
  function automatic void taylor(input longint unsigned x,
                                 output longint unsigned sn, output longint unsigned cs);
    longint unsigned x2, ts, tc;
    longint ss, sc;
    x2 = (x * x) >> 32;
    ts = x;
    tc = 64'd1 << 32;
    ss = longint'(x);
    sc = longint'(tc);
    for (int k = 1; k <= 6; k++) begin
      ts = ((ts * x2) >> 32) / longint'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 32) / longint'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        ss -= longint'(ts);
        sc -= longint'(tc);
      end else begin
        ss += longint'(ts);
        sc += longint'(tc);
      end
    end
    sn = (ss < 0) ? 0 : longint'(ss);
    cs = (sc < 0) ? 0 : longint'(sc);
  endfunction

  function automatic int round_q14(input longint unsigned v);
    longint unsigned r;
    r = (v + (64'd1 << 17)) >> 18;
    if (r > 16384) r = 16384;
    return int'(r);
  endfunction

  // Quadrant fold, series, unfold
  function automatic void phase_trig(input logic [16:0] ph, output int s, output int c);
    logic [1:0] q;
    int r, ps, pc;
    logic fold;
    longint unsigned a, x, sn, cs;
    q = ph[15:14];
    r = int'(ph[13:0]);
    fold = r > 8192;
    a = fold ? longint'(16384 - r) : longint'(r);
    x = (a * 64'd6746518852 + 64'd8192) >> 14;
    taylor(x, sn, cs);
    ps = round_q14(fold ? cs : sn);
    pc = round_q14(fold ? sn : cs);
    case (q)
      2'd0: begin s = ps;  c = pc;  end
      2'd1: begin s = pc;  c = -ps; end
      2'd2: begin s = -ps; c = -pc; end
      default: begin s = -pc; c = ps; end
    endcase
  endfunction

  // Symmetric rounding of trig * radius at 14 fraction bits
  function automatic int scale_radius(input int t, input logic [15:0] rad);
    longint unsigned m;
    int v;
    m = longint'((t < 0) ? -t : t) * longint'(rad);
    v = int'((m + 64'd8192) >> 14);
    return (t < 0) ? -v : v;
  endfunction

  function automatic void predict_slice(input logic [9:0] idx);
    vertex_t vx;
    logic [16:0] ph[2];
    int sn[2], cs[2];
    int e;
    logic inner;
    logic [15:0] rad;
    vx = '0;
    if (seg_count == 0 || seg_count > 1024 || {1'b0, idx} >= seg_count) begin
      vx.err = 1'b1;
      vx.last = 1'b1;
      vertex_q.push_back(vx);
      return;
    end
    ph[0] = 17'(({22'd0, idx} << 16) / seg_count);
    ph[1] = 17'(({22'd0, idx} + 32'd1 << 16) / seg_count);
    for (int j = 0; j < 2; j++) phase_trig(ph[j], sn[j], cs[j]);
    for (int k = 0; k < VERTS; k++) begin
      e = USE_NEXT[k];
      inner = USE_INNER[k];
      rad = inner ? rad_inner : rad_outer;
      vx = '0;
      vx.px = 17'(scale_radius(-sn[e], rad));
      if (!shape_cyl) begin
        vx.py = 17'(scale_radius(cs[e], rad));
        vx.nz = 16'sd16384;
      end else begin
        vx.py = inner ? 17'sd0 : 17'(height);
        vx.pz = 17'(scale_radius(cs[e], rad));
        vx.nx = 16'(-sn[e]);
        vx.nz = 16'(cs[e]);
      end
      vx.u = ph[e];
      vx.v = inner;
      vx.last = (k == VERTS - 1);
      vertex_q.push_back(vx);
    end
  endfunction

  always @(posedge clk) begin
    vertex_t got, want;
    if (rst) begin
      shape_cyl <= 1'b0;
      seg_count <= 11'd32;
      rad_outer <= 16'd256;
      rad_inner <= 16'd128;
      height    <= 16'sd256;
      vertex_q.delete();
      fails <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SHAPE_MODE:    shape_cyl <= cfg_data[0];
          CFG_SEGMENT_COUNT: seg_count <= cfg_data[10:0];
          CFG_OUTER_RADIUS:  rad_outer <= cfg_data;
          CFG_INNER_RADIUS:  rad_inner <= cfg_data;
          CFG_WALL_HEIGHT:   height    <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_slice(segment_index);
      if (out_valid && !out_stall) begin
        got = '{pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                index_error, last_vertex};
        if (vertex_q.size() == 0) begin
          if (fails < 10) $display("unexpected vertex %p", got);
          fails <= fails + 1;
        end else begin
          want = vertex_q.pop_front();
          if (got !== want) begin
            if (fails < 10) $display("vertex mismatch: expected %p actual %p", want, got);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

[sim/tb_ring_cylinder_segment_tessellator.sv]
// Stimulus and verdict for the ring/cylinder segment tessellator
module tb_ring_cylinder_segment_tessellator;
  timeunit 1ns;
  timeprecision 1ps;
  import rcst_pkg::*;

  localparam logic [2:0] CFG_SPARE = CFG_WALL_HEIGHT + 3'd1;  // no register here
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [9:0] segment_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [16:0] pos_x, pos_y, pos_z;
  logic [16:0] tex_u;
  logic tex_v;
  logic signed [15:0] norm_x, norm_y, norm_z;
  logic index_error, last_vertex;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int pending, fails;
  int idle_mode = 0;  // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
  int cycles = 0;
  int cur_count = 32;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ring_cylinder_segment_tessellator uut (.*);

  rcst_checker chk (.*);

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** ring_cylinder_segment_tessellator: FAILED **");
      $finish;
    end
  end

  // Receiver back-pressure, independent of out_valid
  always @(posedge clk) begin
    case (idle_mode)
      2: out_stall <= $urandom_range(99) < 85;
      3: out_stall <= $urandom_range(99) < 8;
      default: out_stall <= 1'b0;
    endcase
  end

  // Present one slice request, hold it until the transfer, then maybe idle
  task automatic send_slice(input logic [9:0] idx);
    int pct;
    in_valid <= 1'b1;
    segment_index <= idx;
    do @(posedge clk); while (in_stall);
    pct = (idle_mode == 1) ? 85 : (idle_mode == 3) ? 8 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drain: wait for every expected vertex, then let the pipe empty
  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Write one register, then idle the channel
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_SEGMENT_COUNT) cur_count = val[10:0];
  endtask

  task automatic set_shape(input logic cyl, input logic [15:0] cnt, input logic [15:0] ro,
                           input logic [15:0] ri, input logic [15:0] wh);
    write_reg(CFG_SHAPE_MODE, {15'd0, cyl});
    write_reg(CFG_SEGMENT_COUNT, cnt);
    write_reg(CFG_OUTER_RADIUS, ro);
    write_reg(CFG_INNER_RADIUS, ri);
    write_reg(CFG_WALL_HEIGHT, wh);
  endtask

  function automatic logic [15:0] pick_count();
    case ($urandom_range(9))
      0: return 16'd1;
      1: return 16'd3;
      2: return 16'd1024;
      3: return ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(2047, 1025));
      4: return 16'($urandom_range(1023, 65));
      default: return 16'($urandom_range(64, 2));
    endcase
  endfunction

  function automatic logic [15:0] pick_radius();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] pick_index();
    if (cur_count >= 1 && cur_count <= 1024 && $urandom_range(99) < 80)
      return 10'($urandom_range(cur_count - 1));
    return 10'($urandom);
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: first slices, last slice, out-of-range, top index
    send_slice(10'd0);
    send_slice(10'd1);
    send_slice(10'd31);
    send_slice(10'd32);
    send_slice(10'd1023);
    drain();

    // Cylinder with one slice: end phase wraps to angle zero
    set_shape(1'b1, 16'd1, 16'hFFFF, 16'd0, 16'h8000);
    send_slice(10'd0);
    send_slice(10'd1);
    drain();
    // Zero slices and counts beyond the maximum flag every index
    write_reg(CFG_SEGMENT_COUNT, 16'd0);
    send_slice(10'd0);
    drain();
    write_reg(CFG_SEGMENT_COUNT, 16'hFFFF);
    send_slice(10'd5);
    drain();
    // Maximum slices, extreme radii and height; spare index does nothing
    set_shape(1'b1, 16'd1024, 16'd0, 16'hFFFF, 16'h7FFF);
    write_reg(CFG_SPARE, 16'hFFFF);
    send_slice(10'd0);
    send_slice(10'd255);
    send_slice(10'd512);
    send_slice(10'd1023);
    drain();
    set_shape(1'b0, 16'd7, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_slice(10'd6);
    send_slice(10'd7);
    send_slice(10'd3);
    drain();

    // Random phases, cycling through the idling modes
    for (int p = 0; p < 12; p++) begin
      set_shape(1'($urandom), pick_count(), pick_radius(), pick_radius(), 16'($urandom));
      idle_mode = p % 4;
      for (int n = 0; n < 19; n++) send_slice(pick_index());
      drain();
      idle_mode = 0;
    end

    repeat (20) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("** ring_cylinder_segment_tessellator: PASSED **");
    end else begin
      $display("** ring_cylinder_segment_tessellator: FAILED **");
    end
    $finish;
  end
endmodule
